// ----- hdl/jue_pkg.sv -----
// ----------------------------------------------------------------------------
// jue_pkg: shared types and constants for the unicode escape converter
// Payload structs for both channels, UTF-8 marker bytes and the hex digit map.
// ----------------------------------------------------------------------------
package jue_pkg;

  typedef struct packed {
    logic [15:0] chars_left;
    logic [31:0] first_hex;
    logic [47:0] next_escape;
  } jue_in_t;

  typedef struct packed {
    logic [2:0] byte_count;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [3:0] chars_used;
  } jue_out_t;

  localparam logic [5:0]  SURR_TAG   = 6'b110110;
  localparam logic [9:0]  TEN_BITS   = 10'b1111111111;
  localparam logic [7:0]  LEAD_FOUR  = 8'b11110000;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'b11100000;
  localparam logic [7:0]  CONT_MARK  = 8'h80;

  localparam logic [7:0]  CHAR_BSLASH = 8'h5C;
  localparam logic [7:0]  CHAR_U      = 8'h75;

  localparam logic [15:0] LEFT_SINGLE = 16'd6;
  localparam logic [15:0] LEFT_PAIR   = 16'd12;

  localparam logic [3:0]  USED_NONE   = 4'd0;
  localparam logic [3:0]  USED_SINGLE = 4'd6;
  localparam logic [3:0]  USED_PAIR   = 4'd12;

  localparam logic [2:0]  COUNT_NONE  = 3'd0;
  localparam logic [2:0]  COUNT_ONE   = 3'd1;
  localparam logic [2:0]  COUNT_TWO   = 3'd2;
  localparam logic [2:0]  COUNT_THREE = 3'd3;
  localparam logic [2:0]  COUNT_FOUR  = 3'd4;

  // 0-9, A-F, a-f as usual; G/g map to 16; anything else maps to 1
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else if (c == 8'h47 || c == 8'h67) begin
      v = 5'd16;
    end else begin
      v = 5'd1;
    end
    return v;
  endfunction

endpackage

// ----- hdl/json_unicode_escape_to_utf8_core.sv -----
// ----------------------------------------------------------------------------
// json_unicode_escape_to_utf8_core: JSON \uXXXX escape to UTF-8
// Input register, conversion logic, result register; one escape per cycle while the output side keeps up.
// ----------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+-----------------------
//  in      | in_valid_i / in_ready_o           | in_data_i  (jue_in_t)
//  out     | out_valid_o / out_ready_i         | out_data_o (jue_out_t)
//
// An escape moves from the input register into the result register before it
// is offered on the output; one escape is taken every cycle while the output
// side keeps up. Each register stage refills in the cycle it drains. Reset
// clears the stage valid flags only. A stall on out_ready_i holds both stages,
// and in_ready_o drops once both are full.
module json_unicode_escape_to_utf8_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jue_pkg::jue_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jue_pkg::jue_out_t out_data_o
);

  logic              in_vld_q;
  jue_pkg::jue_in_t  in_q;
  logic              out_vld_q;
  jue_pkg::jue_out_t out_q;
  jue_pkg::jue_out_t conv_res;
  logic              out_room;
  logic              in_room;

  assign out_room   = !out_vld_q || out_ready_i;
  assign in_room    = !in_vld_q || out_room;
  assign in_ready_o = in_room;

  jue_conv u_conv (
    .esc_i (in_q),
    .res_o (conv_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_room) begin
        in_vld_q <= in_valid_i;
      end
      if (out_room) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_room && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (out_room && in_vld_q) begin
      out_q <= conv_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/jue_conv.sv -----
// ----------------------------------------------------------------------------
// jue_conv: escape text to UTF-8 bytes
// Decodes the hex digits, detects a high surrogate pair and packs the bytes.
// ----------------------------------------------------------------------------
module jue_conv (
  input  jue_pkg::jue_in_t  esc_i,
  output jue_pkg::jue_out_t res_o
);

  logic [4:0]  h0, h1, h2, h3;
  logic [4:0]  n3, n4, n5;
  logic [8:0]  hi8;
  logic [16:0] cp;
  logic [12:0] a2_full;
  logic [9:0]  a1, a2;
  logic [4:0]  plane;
  logic        is_high;
  logic        has_slash_u;

  assign h0 = jue_pkg::hex_val(esc_i.first_hex[31:24]);
  assign h1 = jue_pkg::hex_val(esc_i.first_hex[23:16]);
  assign h2 = jue_pkg::hex_val(esc_i.first_hex[15:8]);
  assign h3 = jue_pkg::hex_val(esc_i.first_hex[7:0]);

  // first hex char of the second escape is ignored
  assign n3 = jue_pkg::hex_val(esc_i.next_escape[23:16]);
  assign n4 = jue_pkg::hex_val(esc_i.next_escape[15:8]);
  assign n5 = jue_pkg::hex_val(esc_i.next_escape[7:0]);

  // shift-OR join; a digit of 16 spills into the next nibble
  assign hi8 = {h0, 4'b0000} | {4'b0000, h1};
  assign cp  = {hi8, 8'b0} | {8'b0, h2, 4'b0000} | {12'b0, h3};

  assign a2_full = {n3, 8'b0} | {4'b0000, n4, 4'b0000} | {8'b0, n5};
  assign a1      = cp[9:0] & jue_pkg::TEN_BITS;
  assign a2      = a2_full[9:0] & jue_pkg::TEN_BITS;
  assign plane   = {1'b0, a1[9:6]} + 5'd1;

  assign is_high     = (hi8[8:2] == {1'b0, jue_pkg::SURR_TAG});
  assign has_slash_u = (esc_i.next_escape[47:40] == jue_pkg::CHAR_BSLASH) &&
                       (esc_i.next_escape[39:32] == jue_pkg::CHAR_U);

  always_comb begin
    res_o            = '0;
    res_o.byte_count = jue_pkg::COUNT_NONE;
    res_o.chars_used = jue_pkg::USED_NONE;
    if (esc_i.chars_left >= jue_pkg::LEFT_SINGLE) begin
      if (is_high) begin
        if (esc_i.chars_left >= jue_pkg::LEFT_PAIR && has_slash_u) begin
          res_o.byte_one   = jue_pkg::LEAD_FOUR | {5'b0, plane[4:2]};
          res_o.byte_two   = jue_pkg::CONT_MARK | {2'b0, plane[1:0], a1[5:2]};
          res_o.byte_three = jue_pkg::CONT_MARK | {2'b0, a1[1:0], a2[9:6]};
          res_o.byte_four  = jue_pkg::CONT_MARK | {2'b0, a2[5:0]};
          res_o.byte_count = jue_pkg::COUNT_FOUR;
          res_o.chars_used = jue_pkg::USED_PAIR;
        end
      end else begin
        res_o.chars_used = jue_pkg::USED_SINGLE;
        if (cp[16:7] == '0) begin
          res_o.byte_one   = {1'b0, cp[6:0]};
          res_o.byte_count = jue_pkg::COUNT_ONE;
        end else if (cp[16:11] == '0) begin
          res_o.byte_one   = jue_pkg::LEAD_TWO | {3'b0, cp[10:6]};
          res_o.byte_two   = jue_pkg::CONT_MARK | {2'b0, cp[5:0]};
          res_o.byte_count = jue_pkg::COUNT_TWO;
        end else if (!cp[16]) begin
          res_o.byte_one   = jue_pkg::LEAD_THREE | {4'b0, cp[15:12]};
          res_o.byte_two   = jue_pkg::CONT_MARK | {2'b0, cp[11:6]};
          res_o.byte_three = jue_pkg::CONT_MARK | {2'b0, cp[5:0]};
          res_o.byte_count = jue_pkg::COUNT_THREE;
        end
        // value above 16 bits: no bytes, six chars still consumed
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for json_unicode_escape_to_utf8_core
// Sends \uXXXX escapes (singles, surrogate pairs, short and broken input,
// odd digit characters) through the valid/ready input channel and checks
// each UTF-8 result against a local predictor, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 5000;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  jue_pkg::jue_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  jue_pkg::jue_out_t out_data;

  bit                gaps_on   = 1'b1;
  jue_pkg::jue_out_t pending_utf8[$];
  int                mismatches  = 0;
  int                n_checked   = 0;
  int                idle_cycles = 0;
  int                count_hist[5];

  json_unicode_escape_to_utf8_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // hex digit map: G/g give 16, which overlaps the next nibble up
  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return 5'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      return 5'(c - "A" + 10);
    end else if (c >= "a" && c <= "f") begin
      return 5'(c - "a" + 10);
    end else if (c == "G" || c == "g") begin
      return 5'd16;
    end
    return 5'd1;
  endfunction

  function automatic jue_pkg::jue_out_t utf8_of_escape(jue_pkg::jue_in_t e);
    jue_pkg::jue_out_t r;
    logic [8:0]        hi8;
    logic [16:0]       cp;
    logic [12:0]       lo_raw;
    logic [9:0]        hi_ten;
    logic [9:0]        lo_ten;
    logic [4:0]        plane;
    r = '0;
    if (e.chars_left >= jue_pkg::LEFT_SINGLE) begin
      hi8 = {digit_value(e.first_hex[31:24]), 4'b0} | 9'(digit_value(e.first_hex[23:16]));
      cp  = {hi8, 8'b0} | 17'({digit_value(e.first_hex[15:8]), 4'b0})
          | 17'(digit_value(e.first_hex[7:0]));
      if (hi8[8:2] == {1'b0, jue_pkg::SURR_TAG}) begin
        if (e.chars_left >= jue_pkg::LEFT_PAIR &&
            e.next_escape[47:40] == jue_pkg::CHAR_BSLASH &&
            e.next_escape[39:32] == jue_pkg::CHAR_U) begin
          hi_ten = cp[9:0];
          // first hex char of the low half is not looked at
          lo_raw = {digit_value(e.next_escape[23:16]), 8'b0}
                 | 13'({digit_value(e.next_escape[15:8]), 4'b0})
                 | 13'(digit_value(e.next_escape[7:0]));
          lo_ten = lo_raw[9:0];
          plane  = {1'b0, hi_ten[9:6]} + 5'd1;
          r.byte_one   = jue_pkg::LEAD_FOUR | {5'b0, plane[4:2]};
          r.byte_two   = jue_pkg::CONT_MARK | {2'b0, plane[1:0], hi_ten[5:2]};
          r.byte_three = jue_pkg::CONT_MARK | {2'b0, hi_ten[1:0], lo_ten[9:6]};
          r.byte_four  = jue_pkg::CONT_MARK | {2'b0, lo_ten[5:0]};
          r.byte_count = jue_pkg::COUNT_FOUR;
          r.chars_used = jue_pkg::USED_PAIR;
        end
      end else begin
        r.chars_used = jue_pkg::USED_SINGLE;
        if (cp <= 17'd127) begin
          r.byte_one   = cp[7:0];
          r.byte_count = jue_pkg::COUNT_ONE;
        end else if (cp <= 17'd2047) begin
          r.byte_one   = jue_pkg::LEAD_TWO | {3'b0, cp[10:6]};
          r.byte_two   = jue_pkg::CONT_MARK | {2'b0, cp[5:0]};
          r.byte_count = jue_pkg::COUNT_TWO;
        end else if (cp <= 17'd65535) begin
          r.byte_one   = jue_pkg::LEAD_THREE | {4'b0, cp[15:12]};
          r.byte_two   = jue_pkg::CONT_MARK | {2'b0, cp[11:6]};
          r.byte_three = jue_pkg::CONT_MARK | {2'b0, cp[5:0]};
          r.byte_count = jue_pkg::COUNT_THREE;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- generators
  function automatic logic [7:0] odd_char();
    case ($urandom_range(3))
      0:       return "G";
      1:       return "g";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  // four hex chars for v, each now and then swapped for an odd character
  function automatic logic [31:0] hex_word(logic [15:0] v);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      w[31 - 8*i -: 8] = ($urandom_range(99) < 5) ? odd_char() : hex_char(v[15 - 4*i -: 4]);
    end
    return w;
  endfunction

  function automatic jue_pkg::jue_in_t escape_item(logic [15:0] left, logic [31:0] hex,
                                                   logic [47:0] nxt);
    jue_pkg::jue_in_t e;
    e.chars_left  = left;
    e.first_hex   = hex;
    e.next_escape = nxt;
    return e;
  endfunction

  // --------------------------------------------------------------- input side
  task automatic send_escape(input jue_pkg::jue_in_t item);
    jue_pkg::jue_out_t want;
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    want = utf8_of_escape(item);
    pending_utf8.push_back(want);
    count_hist[want.byte_count]++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_utf8.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------- output side
  always @(negedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    jue_pkg::jue_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_utf8.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_utf8.pop_front();
        n_checked++;
        if (out_data.byte_count !== want.byte_count || out_data.byte_one !== want.byte_one ||
            out_data.byte_two !== want.byte_two || out_data.byte_three !== want.byte_three ||
            out_data.byte_four !== want.byte_four || out_data.chars_used !== want.chars_used) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d:", n_checked);
            $display("  exp count %0d bytes %h %h %h %h used %0d", want.byte_count,
                     want.byte_one, want.byte_two, want.byte_three, want.byte_four,
                     want.chars_used);
            $display("  got count %0d bytes %h %h %h %h used %0d", out_data.byte_count,
                     out_data.byte_one, out_data.byte_two, out_data.byte_three,
                     out_data.byte_four, out_data.chars_used);
          end
        end
      end
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    send_escape(escape_item(16'd0,     "0041", "\\u0041"));  // nothing to read
    send_escape(escape_item(16'd5,     "0041", "\\u0041"));  // short escape
    send_escape(escape_item(16'd6,     "0000", 48'h0));
    send_escape(escape_item(16'd6,     "007F", 48'hFFFF_FFFF_FFFF));
    send_escape(escape_item(16'd7,     "0080", "\\u0000"));
    send_escape(escape_item(16'd6,     "07ff", "\\u0000"));
    send_escape(escape_item(16'd6,     "0800", "\\u0000"));
    send_escape(escape_item(16'hFFFF,  "FFFF", "\\uFFFF"));
    send_escape(escape_item(16'd6,     "DC00", "\\uDC00"));  // lone low half
    send_escape(escape_item(16'd12,    "D800", "\\uDC00"));  // lowest pair
    send_escape(escape_item(16'hFFFF,  "dbff", "\\udfff"));  // highest plane
    send_escape(escape_item(16'd12,    "D83D", "\\uDE00"));
    send_escape(escape_item(16'd11,    "D83D", "\\uDE00"));  // pair without room
    send_escape(escape_item(16'd6,     "D800", "\\uDC00"));
    send_escape(escape_item(16'd20,    "D800", "xuDC00"));   // no backslash
    send_escape(escape_item(16'd20,    "D800", "\\UDC00"));  // no 'u'
    send_escape(escape_item(16'd12,    "DAAA", "\\uZZZZ"));  // low half unchecked
    send_escape(escape_item(16'd12,    "DB00", "\\u0gG9"));
    send_escape(escape_item(16'd6,     "G000", "\\u0000"));  // overlap past 0xFFFF
    send_escape(escape_item(16'd6,     "gggg", "\\u0000"));
    send_escape(escape_item(16'd6,     "0G00", "\\u0000"));  // overlap, still in range
    send_escape(escape_item(16'd6,     "zz!~", "\\u0000"));  // non-digits read as 1
    send_escape(escape_item(16'd6,     "CG0G", "\\u0000"));
    hold_until_drained();
  endtask

  task automatic test_pairs(input int n);
    logic [15:0] hi_half;
    logic [15:0] lo_half;
    logic [15:0] left;
    logic [47:0] nxt;
    for (int i = 0; i < n; i++) begin
      hi_half = 16'hD800 | 16'($urandom_range(1023));
      lo_half = ($urandom_range(9) == 0) ? 16'($urandom) : (16'hDC00 | 16'($urandom_range(1023)));
      nxt     = {jue_pkg::CHAR_BSLASH, jue_pkg::CHAR_U, hex_word(lo_half)};
      left    = 16'($urandom_range(12, 400));
      case ($urandom_range(19))
        0:       left = 16'($urandom_range(6, 11));
        1:       left = 16'($urandom);
        2:       nxt[47:40] = 8'($urandom);
        3:       nxt[39:32] = 8'($urandom);
        default: ;
      endcase
      if (i % 100 == 99) hold_until_drained();
      send_escape(escape_item(left, hex_word(hi_half), nxt));
    end
  endtask

  task automatic test_mixed(input int n);
    logic [15:0]      cp;
    logic [15:0]      left;
    jue_pkg::jue_in_t e;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0:       cp = 16'($urandom_range(127));
        1:       cp = 16'($urandom_range(128, 2047));
        default: cp = 16'($urandom_range(2048, 65535));
      endcase
      left = ($urandom_range(9) == 0) ? 16'($urandom_range(5)) : 16'($urandom_range(6, 200));
      e = escape_item(left, hex_word(cp),
                      {jue_pkg::CHAR_BSLASH, jue_pkg::CHAR_U, hex_word(16'($urandom))});
      // about a third is raw noise on every field
      if ($urandom_range(2) == 0) begin
        e = escape_item(16'($urandom), $urandom, {16'($urandom), 32'($urandom)});
      end
      if (i % 150 == 149) hold_until_drained();
      send_escape(e);
    end
  endtask

  task automatic test_back_to_back(input int n);
    hold_until_drained();
    gaps_on = 1'b0;
    test_pairs(n / 2);
    test_mixed(n - n / 2);
    hold_until_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_pairs(220);
    test_mixed(360);
    test_back_to_back(150);

    hold_until_drained();
    repeat (8) @(posedge clk);

    $display("checked %0d escapes: %0d rejected, %0d/%0d/%0d/%0d of one to four bytes",
             n_checked, count_hist[0], count_hist[1], count_hist[2], count_hist[3],
             count_hist[4]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_utf8.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
